// ===== rtl/assert_macros.svh =====
// shared assertion macros, all sampled on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsnh_pkg.sv =====
package rsnh_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] DIR_NEG_Y = 2'd0;
  localparam logic [1:0] DIR_POS_Y = 2'd1;
  localparam logic [1:0] DIR_NEG_X = 2'd2;
  localparam logic [1:0] DIR_POS_X = 2'd3;

  localparam logic signed [15:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [15:0] COORD_MIN = -16'sh8000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] seg_ax;
    logic signed [15:0] seg_ay;
    logic signed [15:0] seg_bx;
    logic signed [15:0] seg_by;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [1:0]         direction;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic               hit_found;
    logic               append_dropped;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
  } seg_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [1:0]         direction;
  } qry_t;

  typedef struct packed {
    logic init;
    logic eval;
  } hit_ctrl_t;

endpackage

// ===== rtl/rsnh_seg_mem.sv =====
module rsnh_seg_mem #(
  parameter int unsigned DEPTH = rsnh_pkg::MAX_SEGMENTS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  rsnh_pkg::seg_t       wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output rsnh_pkg::seg_t       rd_data
);

  rsnh_pkg::seg_t mem [DEPTH];
  rsnh_pkg::seg_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rsnh_hit_unit.sv =====
module rsnh_hit_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  rsnh_pkg::hit_ctrl_t ctrl,
  input  rsnh_pkg::qry_t      qry_in,
  input  rsnh_pkg::seg_t      seg,
  output logic signed [15:0]  hit_x,
  output logic signed [15:0]  hit_y,
  output logic                hit_found
);

  rsnh_pkg::qry_t     qry_r;
  logic signed [15:0] best_r, best_nxt;
  logic signed [15:0] hx_r, hx_nxt;
  logic signed [15:0] hy_r, hy_nxt;
  logic               found_r, found_nxt;

  logic               along_y, larger, in_larger;
  logic               skip, in_span, on_ray, better, take;
  logic signed [15:0] across, a0, a1, along, c0, c1;
  logic signed [15:0] lo_a, hi_a, lo_c, hi_c, e;
  logic signed [15:0] sentinel;

  always_comb begin
    along_y = (qry_r.direction == rsnh_pkg::DIR_NEG_Y) ||
              (qry_r.direction == rsnh_pkg::DIR_POS_Y);
    larger  = (qry_r.direction == rsnh_pkg::DIR_POS_Y) ||
              (qry_r.direction == rsnh_pkg::DIR_POS_X);

    skip = ((seg.ax == qry_r.start_x) && (seg.ay == qry_r.start_y)) ||
           ((seg.bx == qry_r.start_x) && (seg.by == qry_r.start_y));

    across = along_y ? qry_r.start_x : qry_r.start_y;
    along  = along_y ? qry_r.start_y : qry_r.start_x;
    a0     = along_y ? seg.ax : seg.ay;
    a1     = along_y ? seg.bx : seg.by;
    c0     = along_y ? seg.ay : seg.ax;
    c1     = along_y ? seg.by : seg.bx;

    lo_a = (a0 < a1) ? a0 : a1;
    hi_a = (a0 > a1) ? a0 : a1;
    lo_c = (c0 < c1) ? c0 : c1;
    hi_c = (c0 > c1) ? c0 : c1;
    // nearest endpoint along the ray
    e    = larger ? lo_c : hi_c;

    in_span = (across >= lo_a) && (across <= hi_a);
    on_ray  = larger ? (along <= e) : (along >= e);
    // ties take the later segment
    better  = larger ? (e <= best_r) : (e >= best_r);
    take    = ctrl.eval && !skip && in_span && on_ray && better;

    in_larger = (qry_in.direction == rsnh_pkg::DIR_POS_Y) ||
                (qry_in.direction == rsnh_pkg::DIR_POS_X);
    sentinel  = in_larger ? rsnh_pkg::COORD_MAX : rsnh_pkg::COORD_MIN;

    best_nxt  = best_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    found_nxt = found_r;
    if (ctrl.init) begin
      best_nxt  = sentinel;
      hx_nxt    = sentinel;
      hy_nxt    = sentinel;
      found_nxt = 1'b0;
    end else if (take) begin
      best_nxt  = e;
      found_nxt = 1'b1;
      hx_nxt    = along_y ? qry_r.start_x : e;
      hy_nxt    = along_y ? e : qry_r.start_y;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      qry_r <= qry_in;
    end
    best_r <= best_nxt;
    hx_r   <= hx_nxt;
    hy_r   <= hy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  assign hit_x     = hx_r;
  assign hit_y     = hy_r;
  assign hit_found = found_r;

endmodule

// ===== rtl/axis_ray_segment_nearest_hit.sv =====
// Segment table with axis-aligned ray queries. A clear or append beat, taken only while idle,
// passes to a response state, which loads its result into the output register once that is free;
// no new beat is taken before then. A query reads the N stored segments one per cycle through the
// single read port of the segment memory and tests each in one shared compare unit, then passes a
// flush state and the response state. Results sit in an output register, so the block takes its
// next beat while an earlier result still waits. No clearing pass follows reset.
`include "assert_macros.svh"

module axis_ray_segment_nearest_hit #(
  parameter int unsigned MAX_SEGMENTS = rsnh_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsnh_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsnh_pkg::out_beat_t out_data
);

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                eval_v_r, eval_v_nxt;
  logic                is_query_r, is_query_nxt;
  rsnh_pkg::out_beat_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsnh_pkg::out_beat_t out_data_r, out_data_nxt;

  logic                accept, full, issue, load_out;
  logic                wr_en;
  rsnh_pkg::seg_t      wr_seg, rd_seg;
  rsnh_pkg::qry_t      qry_in;
  rsnh_pkg::hit_ctrl_t hit_ctrl;
  logic signed [15:0]  hit_x, hit_y;
  logic                hit_found;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (cnt_r >= CNT_MAX);
  assign wr_en     = accept && (in_data.req_type == rsnh_pkg::REQ_APPEND) && !full;
  assign issue     = (state_r == ST_SCAN) && (idx_r < cnt_r);
  assign load_out  = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  assign wr_seg.ax = in_data.seg_ax;
  assign wr_seg.ay = in_data.seg_ay;
  assign wr_seg.bx = in_data.seg_bx;
  assign wr_seg.by = in_data.seg_by;

  assign qry_in.start_x   = in_data.start_x;
  assign qry_in.start_y   = in_data.start_y;
  assign qry_in.direction = in_data.direction;

  assign hit_ctrl.init = accept && (in_data.req_type == rsnh_pkg::REQ_QUERY);
  assign hit_ctrl.eval = eval_v_r;

  rsnh_seg_mem #(
    .DEPTH (MAX_SEGMENTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (wr_seg),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_seg)
  );

  rsnh_hit_unit u_hit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (hit_ctrl),
    .qry_in    (qry_in),
    .seg       (rd_seg),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_found (hit_found)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    is_query_nxt  = is_query_r;
    res_nxt       = res_r;
    eval_v_nxt    = issue;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt      = '0;
          is_query_nxt = 1'b0;
          state_nxt    = ST_RESP;
          case (in_data.req_type)
            rsnh_pkg::REQ_CLEAR: begin
              cnt_nxt = '0;
            end
            rsnh_pkg::REQ_APPEND: begin
              if (full) begin
                res_nxt.append_dropped = 1'b1;
              end else begin
                cnt_nxt = cnt_r + CNT_ONE;
              end
            end
            rsnh_pkg::REQ_QUERY: begin
              is_query_nxt = 1'b1;
              idx_nxt      = '0;
              state_nxt    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + CNT_ONE;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // hit registers already hold the last segment's update
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (is_query_r) begin
            out_data_nxt.hit_x          = hit_x;
            out_data_nxt.hit_y          = hit_y;
            out_data_nxt.hit_found      = hit_found;
            out_data_nxt.append_dropped = 1'b0;
          end else begin
            out_data_nxt = res_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      eval_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      eval_v_r    <= eval_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_query_r <= is_query_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_MAX, "segment count beyond table depth")
  `ASSERT_ALWAYS(a_idx_bound, (state_r != ST_SCAN) || (idx_r <= cnt_r),
                 "scan index ran past segment count")
  `ASSERT_ALWAYS(a_eval_phase, !eval_v_r || (state_r == ST_SCAN) || (state_r == ST_FLUSH),
                 "segment evaluated outside a scan")
  `ASSERT_NEXT(a_query_scan, hit_ctrl.init, (state_r == ST_SCAN) && (idx_r == '0),
               "query did not start its scan at entry zero")

endmodule
